>>> rtl/lebuf_pkg.sv
package lebuf_pkg;

   // line sizing
   localparam int LINE_CAPACITY = 64;
   localparam int STORE_DEPTH   = 64;
   localparam int CAP_CLAMPED   = (LINE_CAPACITY > STORE_DEPTH) ? STORE_DEPTH :
                                  ((LINE_CAPACITY < 2) ? 2 : LINE_CAPACITY);
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int CHAR_W        = 8;
   localparam int OPC_W         = 3;
   localparam logic [ADDR_W-1:0] MAX_CHARS = ADDR_W'(CAP_CLAMPED - 1);
   localparam logic [CHAR_W-1:0] SPACE_CHAR = CHAR_W'(32);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // opcode encoding on the request port
   localparam logic [OPC_W-1:0] OP_INSERT    = 3'd0;
   localparam logic [OPC_W-1:0] OP_BACKSPACE = 3'd1;
   localparam logic [OPC_W-1:0] OP_DELETE    = 3'd2;
   localparam logic [OPC_W-1:0] OP_LEFT      = 3'd3;
   localparam logic [OPC_W-1:0] OP_RIGHT     = 3'd4;

   typedef enum logic [2:0] {
      CMD_INSERT,
      CMD_REFUSE,
      CMD_BACKSPACE,
      CMD_DELETE,
      CMD_LEFT,
      CMD_RIGHT,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] char_code;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT_RIGHT,
      ST_SHIFT_LEFT,
      ST_RENDER
   } back_state_type;

endpackage

>>> rtl/line_edit_buffer_top.sv
// Line edit buffer: holds one text line and a cursor, applies edit commands
// and after each command plays the line back as a run of result words.
//
// Request channel: a command word (req_opcode, req_char_code) is taken at a
// clock edge where start is high and busy is low. A two-entry command queue
// sits between the decode front and the edit/render back, so busy only rises
// when two commands are waiting behind the one being worked on.
//
// Result channel: rsp_strobe marks each word for one cycle; the receiver
// cannot hold words off. A run has line_length+1 words back to back, the
// last one a trailing space with rsp_last_of_run set.
//
// Sequence: a command is picked up from the queue; an insert then moves the
// tail right from the line end down to the cursor, a backspace or delete
// moves it left from the removed place, unless no tail moves; then the run
// plays, each word shown in the cycle after its ram read. The ram gives one
// read and one write per cycle.
// Reset: synchronous; empties the line, puts the cursor at 0 and drops
// queued commands.
module line_edit_buffer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lebuf_pkg::OPC_W-1:0]   req_opcode,
   input  logic [lebuf_pkg::CHAR_W-1:0]  req_char_code,
   output logic                          rsp_strobe,
   output logic [lebuf_pkg::CHAR_W-1:0]  rsp_shown_char,
   output logic                          rsp_highlighted,
   output logic                          rsp_last_of_run,
   output logic [lebuf_pkg::ADDR_W-1:0]  rsp_cursor_index,
   output logic [lebuf_pkg::ADDR_W-1:0]  rsp_line_length,
   output logic                          rsp_refused
);
   import lebuf_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // decode and command queue
   lebuf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_char_code (req_char_code),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   // edit and render
   lebuf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_shown_char   (rsp_shown_char),
      .rsp_highlighted  (rsp_highlighted),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_cursor_index (rsp_cursor_index),
      .rsp_line_length  (rsp_line_length),
      .rsp_refused      (rsp_refused)
   );

endmodule

>>> rtl/lebuf_ram.sv
module lebuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lebuf_front.sv
module lebuf_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [lebuf_pkg::OPC_W-1:0]      req_opcode,
   input  logic [lebuf_pkg::CHAR_W-1:0]     req_char_code,
   output logic                             cmd_valid,
   output lebuf_pkg::cmd_type               cmd,
   input  logic                             cmd_pop
);
   import lebuf_pkg::*;

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             decoded;
   logic                push;

   // classify the incoming word
   always_comb begin
      decoded.char_code = req_char_code;
      case (req_opcode)
         OP_INSERT:    decoded.kind = (req_char_code == '0) ? CMD_REFUSE : CMD_INSERT;
         OP_BACKSPACE: decoded.kind = CMD_BACKSPACE;
         OP_DELETE:    decoded.kind = CMD_DELETE;
         OP_LEFT:      decoded.kind = CMD_LEFT;
         OP_RIGHT:     decoded.kind = CMD_RIGHT;
         default:      decoded.kind = CMD_NOP;
      endcase
   end

   // queue occupancy and pointers
   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = start && !busy;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? QPTR_W'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> rtl/lebuf_back.sv
module lebuf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  lebuf_pkg::cmd_type            cmd,
   output logic                          cmd_pop,
   output logic                          rsp_strobe,
   output logic [lebuf_pkg::CHAR_W-1:0]  rsp_shown_char,
   output logic                          rsp_highlighted,
   output logic                          rsp_last_of_run,
   output logic [lebuf_pkg::ADDR_W-1:0]  rsp_cursor_index,
   output logic [lebuf_pkg::ADDR_W-1:0]  rsp_line_length,
   output logic                          rsp_refused
);
   import lebuf_pkg::*;

   back_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]   cursor_ff, cursor_in;
   logic                refused_ff, refused_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic                rnd_valid_ff, rnd_valid_in;
   logic [ADDR_W-1:0]   rnd_pos_ff, rnd_pos_in;
   logic                rnd_last_ff, rnd_last_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [CHAR_W-1:0]   ram_wr_data;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [CHAR_W-1:0]   ram_rd_data;

   logic                line_full;
   logic                shr_issue;
   logic                shl_issue;
   logic                render_last;

   lebuf_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (STORE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // loop conditions
   assign line_full   = (count_ff >= MAX_CHARS);
   assign shr_issue   = (idx_ff > cursor_ff);
   assign shl_issue   = (({1'b0, idx_ff} + (ADDR_W+1)'(1)) < {1'b0, count_ff});
   assign render_last = (idx_ff == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_INSERT:    state_in = line_full ? ST_RENDER : ST_SHIFT_RIGHT;
                  CMD_BACKSPACE: state_in = (cursor_ff != '0) ? ST_SHIFT_LEFT : ST_RENDER;
                  CMD_DELETE:    state_in = (cursor_ff < count_ff) ? ST_SHIFT_LEFT : ST_RENDER;
                  default:       state_in = ST_RENDER;
               endcase
            end
         end
         ST_SHIFT_RIGHT: begin
            if (!shr_issue && !pend_valid_ff) begin
               state_in = ST_RENDER;
            end
         end
         ST_SHIFT_LEFT: begin
            if (!shl_issue && !pend_valid_ff) begin
               state_in = ST_RENDER;
            end
         end
         ST_RENDER: begin
            if (render_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control per state
   always_comb begin
      cmd_pop       = 1'b0;
      idx_in        = idx_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      refused_in    = refused_ff;
      char_in       = char_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = pend_addr_ff;
      rnd_valid_in  = 1'b0;
      rnd_pos_in    = rnd_pos_ff;
      rnd_last_in   = rnd_last_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = pend_addr_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               char_in    = cmd.char_code;
               refused_in = 1'b0;
               idx_in     = '0;
               case (cmd.kind)
                  CMD_INSERT: begin
                     if (line_full) begin
                        refused_in = 1'b1;
                     end else begin
                        idx_in = count_ff;
                     end
                  end
                  CMD_REFUSE: refused_in = 1'b1;
                  CMD_BACKSPACE: begin
                     if (cursor_ff != '0) begin
                        cursor_in = cursor_ff - ADDR_W'(1);
                        idx_in    = cursor_ff - ADDR_W'(1);
                     end
                  end
                  CMD_DELETE: begin
                     if (cursor_ff < count_ff) begin
                        idx_in = cursor_ff;
                     end
                  end
                  CMD_LEFT: begin
                     if (cursor_ff != '0) begin
                        cursor_in = cursor_ff - ADDR_W'(1);
                     end
                  end
                  CMD_RIGHT: begin
                     if (cursor_ff < count_ff) begin
                        cursor_in = cursor_ff + ADDR_W'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end
         // tail moves right: store[i] = store[i-1], from the end down to the cursor
         ST_SHIFT_RIGHT: begin
            if (pend_valid_ff) begin
               ram_we = 1'b1;
            end
            if (shr_issue) begin
               ram_rd_addr   = idx_ff - ADDR_W'(1);
               pend_valid_in = 1'b1;
               pend_addr_in  = idx_ff;
               idx_in        = idx_ff - ADDR_W'(1);
            end else if (!pend_valid_ff) begin
               ram_we      = 1'b1;
               ram_wr_addr = cursor_ff;
               ram_wr_data = char_ff;
               count_in    = count_ff + ADDR_W'(1);
               cursor_in   = cursor_ff + ADDR_W'(1);
               idx_in      = '0;
            end
         end
         // tail moves left: store[i] = store[i+1], from the removed place upward
         ST_SHIFT_LEFT: begin
            if (pend_valid_ff) begin
               ram_we = 1'b1;
            end
            if (shl_issue) begin
               ram_rd_addr   = idx_ff + ADDR_W'(1);
               pend_valid_in = 1'b1;
               pend_addr_in  = idx_ff;
               idx_in        = idx_ff + ADDR_W'(1);
            end else if (!pend_valid_ff) begin
               count_in = count_ff - ADDR_W'(1);
               idx_in   = '0;
            end
         end
         // one run position per cycle, character arrives from the ram in the next cycle
         ST_RENDER: begin
            ram_rd_addr  = idx_ff;
            rnd_valid_in = 1'b1;
            rnd_pos_in   = idx_ff;
            rnd_last_in  = render_last;
            idx_in       = render_last ? '0 : idx_ff + ADDR_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         count_ff      <= '0;
         cursor_ff     <= '0;
         refused_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rnd_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         cursor_ff     <= cursor_in;
         refused_ff    <= refused_in;
         pend_valid_ff <= pend_valid_in;
         rnd_valid_ff  <= rnd_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      pend_addr_ff <= pend_addr_in;
      rnd_pos_ff   <= rnd_pos_in;
      rnd_last_ff  <= rnd_last_in;
   end

   // result word
   assign rsp_strobe       = rnd_valid_ff;
   assign rsp_shown_char   = rnd_last_ff ? SPACE_CHAR : ram_rd_data;
   assign rsp_highlighted  = (rnd_pos_ff == cursor_ff);
   assign rsp_last_of_run  = rnd_last_ff;
   assign rsp_cursor_index = cursor_ff;
   assign rsp_line_length  = count_ff;
   assign rsp_refused      = refused_ff;

endmodule

>>> rtl/lebuf_checker.sv
module lebuf_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          rsp_strobe,
   input  logic                          rsp_last_of_run,
   input  logic [lebuf_pkg::ADDR_W-1:0]  rsp_cursor_index,
   input  logic [lebuf_pkg::ADDR_W-1:0]  rsp_line_length,
   input  logic                          rsp_refused
);
   import lebuf_pkg::*;

   // a run never pauses before its trailing space
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_run |=> rsp_strobe)
      else $error("run broke before trailing space");

   // a trailing space is never followed directly by another word
   a_gap_after_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_of_run |=> !rsp_strobe)
      else $error("run followed directly by another word");

   // line state is constant across one run
   a_run_state_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_run |=>
         $stable(rsp_cursor_index) && $stable(rsp_line_length) && $stable(rsp_refused))
      else $error("line state changed within a run");

   // cursor never passes the end of the line
   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_cursor_index <= rsp_line_length)
      else $error("cursor beyond line end");

   // busy only rises right after an accepted word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose with no word offered");

endmodule

bind line_edit_buffer_top lebuf_checker u_lebuf_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_last_of_run  (rsp_last_of_run),
   .rsp_cursor_index (rsp_cursor_index),
   .rsp_line_length  (rsp_line_length),
   .rsp_refused      (rsp_refused)
);
